### rtl/fat16_cluster_chain_streamer_assert.svh
// ----------------------------------------------------------------------------
// FAT16 cluster chain streamer assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef FAT16_CLUSTER_CHAIN_STREAMER_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_STREAMER_ASSERT_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define FCCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// cond must never be true outside reset
`define FCCS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define FCCS_ASSERT(lbl, clk, rstn, prop)
`define FCCS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### rtl/fccs_pkg.sv
// ----------------------------------------------------------------------------
// FAT16 cluster chain streamer package
// Shared widths, constants, result kinds, command codes and register indices.
// ----------------------------------------------------------------------------
package fccs_pkg;

  localparam int unsigned SectorBytesDefault = 512;

  localparam int unsigned ClusterW = 16;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned AddrW    = 25;
  localparam int unsigned CountW   = 10;
  localparam int unsigned SpcW     = 6;
  localparam int unsigned LbaW     = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ClusterW-1:0] EndMark          = 16'hFFF8;
  localparam logic [ClusterW-1:0] FirstDataCluster = 16'd2;
  localparam logic [SpcW-1:0]     SpcMax           = 6'd32;
  localparam logic [CountW-1:0]   FatEntryBytes    = 10'd2;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FAT  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } fccs_kind_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } fccs_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SPC       = 4'd0,
    REG_DATA_LBA  = 4'd1,
    REG_FAT_LBA   = 4'd2,
    REG_CHAIN_LIM = 4'd3
  } fccs_reg_e;

endpackage

### rtl/fat16_cluster_chain_streamer.sv
// ----------------------------------------------------------------------------
// FAT16 cluster chain streamer
// Turns one file's FAT16 cluster chain into data sector and FAT entry reads.
// ----------------------------------------------------------------------------
// An input beat taken in idle goes to the evaluate state, which registers a
// done or error result or starts a cluster's n sector reads (n <= 32), then
// a FAT entry read or, once the file ends, a done result; no input is taken
// before an item's last result. One result per cycle, unless stalled, from
// the shared address unit, which the sequencer steps once per emitted sector.
// Output stalls hold the sequencer. Reset (rst_ni low, async) clears the
// walk state and loads the register defaults; the block is ready at once.
// ----------------------------------------------------------------------------
`include "fat16_cluster_chain_streamer_assert.svh"

module fat16_cluster_chain_streamer
  import fccs_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = SectorBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // cluster[15:0], file_size[47:16]
  input  logic                s_axis_tuser,  // cmd[0]
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,  // byte_address[24:0], byte_count[34:25], zero[39:35]
  output logic [1:0]          m_axis_tuser,  // kind[1:0]
  output logic                m_axis_tlast
);

  localparam int unsigned LenW = $clog2(SECTOR_BYTES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SECT,
    ST_FAT,
    ST_DONE
  } state_e;

  // configuration registers
  logic [SpcW-1:0]     spc_q;
  logic [LbaW-1:0]     data_lba_q;
  logic [LbaW-1:0]     fat_lba_q;
  logic [ClusterW-1:0] chain_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q         <= 6'd1;
      data_lba_q    <= 16'd289;
      fat_lba_q     <= 16'd1;
      chain_limit_q <= 16'hFFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SPC:       spc_q         <= cfg_data_i[SpcW-1:0];
        REG_DATA_LBA:  data_lba_q    <= cfg_data_i;
        REG_FAT_LBA:   fat_lba_q     <= cfg_data_i;
        REG_CHAIN_LIM: chain_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // walk state and output register
  state_e              state_q;
  logic [ClusterW-1:0] cur_q;
  logic [SizeW-1:0]    rem_q;
  logic [ClusterW-1:0] visited_q;
  logic                awaiting_q;
  logic                stray_q;
  logic [AddrW-1:0]    lba_q;
  logic [SpcW-1:0]     sec_cnt_q;

  logic                out_valid_q;
  fccs_kind_e          out_kind_q;
  logic [AddrW-1:0]    out_addr_q;
  logic [CountW-1:0]   out_count_q;
  logic                out_last_q;

  logic                in_fire;
  logic                slot_free;
  logic                emit;
  logic [SpcW-1:0]     spc_eff;
  logic [LenW-1:0]     len;
  logic [SizeW-1:0]    rem_d;
  logic [SpcW-1:0]     sec_cnt_d;
  logic                bad;
  logic [21:0]         base;
  logic [AddrW-1:0]    au_sector;
  logic [AddrW-1:0]    au_offset;
  logic [AddrW-1:0]    au_addr;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign slot_free     = !out_valid_q || m_axis_tready;

  always_comb begin
    if (spc_q == '0) begin
      spc_eff = 6'd1;
    end else if (spc_q > SpcMax) begin
      spc_eff = SpcMax;
    end else begin
      spc_eff = spc_q;
    end
    if (rem_q > SizeW'(SECTOR_BYTES)) begin
      len = LenW'(SECTOR_BYTES);
    end else begin
      len = rem_q[LenW-1:0];
    end
    rem_d     = rem_q - SizeW'(len);
    sec_cnt_d = sec_cnt_q + 6'd1;
    bad       = (cur_q < FirstDataCluster) || (cur_q >= EndMark) ||
                (visited_q >= chain_limit_q);
    base      = 22'(data_lba_q) + 22'(cur_q - FirstDataCluster) * 22'(spc_eff);
    // load a new result beat this cycle
    emit      = slot_free &&
                ((state_q == ST_SECT) || (state_q == ST_FAT) || (state_q == ST_DONE) ||
                 ((state_q == ST_EVAL) && (stray_q || (rem_q == '0) || bad)));
    // FAT entry: fat start sector plus two bytes per cluster
    if (state_q == ST_FAT) begin
      au_sector = AddrW'(fat_lba_q);
      au_offset = AddrW'({cur_q, 1'b0});
    end else begin
      au_sector = lba_q;
      au_offset = '0;
    end
  end

  fccs_addr_unit #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_addr_unit (
    .sector_i(au_sector),
    .offset_i(au_offset),
    .addr_o  (au_addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      rem_q       <= '0;
      visited_q   <= '0;
      awaiting_q  <= 1'b0;
      stray_q     <= 1'b0;
      lba_q       <= '0;
      sec_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_DONE;
      out_addr_q  <= '0;
      out_count_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_EVAL;
            if (s_axis_tuser == CMD_START) begin
              cur_q     <= s_axis_tdata[15:0];
              rem_q     <= s_axis_tdata[47:16];
              visited_q <= '0;
              stray_q   <= 1'b0;
            end else if (awaiting_q) begin
              cur_q   <= s_axis_tdata[15:0];
              stray_q <= 1'b0;
            end else begin
              stray_q <= 1'b1;
            end
          end
        end
        ST_EVAL: begin
          if (slot_free) begin
            if (stray_q) begin
              // next entry with no walk in progress: report, keep state
              out_kind_q  <= KIND_ERR;
              out_addr_q  <= '0;
              out_count_q <= '0;
              out_last_q  <= 1'b1;
              state_q     <= ST_IDLE;
            end else if (rem_q == '0) begin
              out_kind_q  <= KIND_DONE;
              out_addr_q  <= '0;
              out_count_q <= '0;
              out_last_q  <= 1'b1;
              awaiting_q  <= 1'b0;
              state_q     <= ST_IDLE;
            end else if (bad) begin
              out_kind_q  <= KIND_ERR;
              out_addr_q  <= '0;
              out_count_q <= '0;
              out_last_q  <= 1'b1;
              awaiting_q  <= 1'b0;
              state_q     <= ST_IDLE;
            end else begin
              visited_q <= visited_q + 16'd1;
              lba_q     <= AddrW'(base);
              sec_cnt_q <= '0;
              state_q   <= ST_SECT;
            end
          end
        end
        ST_SECT: begin
          if (slot_free) begin
            out_kind_q  <= KIND_DATA;
            out_addr_q  <= au_addr;
            out_count_q <= len[CountW-1:0];
            out_last_q  <= 1'b0;
            rem_q       <= rem_d;
            lba_q       <= lba_q + AddrW'(1);
            sec_cnt_q   <= sec_cnt_d;
            if (rem_d == '0) begin
              state_q <= ST_DONE;
            end else if (sec_cnt_d == spc_eff) begin
              state_q <= ST_FAT;
            end
          end
        end
        ST_FAT: begin
          if (slot_free) begin
            out_kind_q  <= KIND_FAT;
            out_addr_q  <= au_addr;
            out_count_q <= FatEntryBytes;
            out_last_q  <= 1'b1;
            awaiting_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_kind_q  <= KIND_DONE;
            out_addr_q  <= '0;
            out_count_q <= '0;
            out_last_q  <= 1'b1;
            awaiting_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_count_q, out_addr_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // only data reads are followed by more results of the same item
  `FCCS_ASSERT(a_last_vs_kind, clk_i, rst_ni,
               m_axis_tvalid |-> ((m_axis_tuser == KIND_DATA) == !m_axis_tlast))
  `FCCS_ASSERT(a_fat_count, clk_i, rst_ni,
               (m_axis_tvalid && m_axis_tuser == KIND_FAT) |->
               (m_axis_tdata[34:25] == FatEntryBytes))
  `FCCS_ASSERT(a_busy_after_take, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)

endmodule

### rtl/fccs_addr_unit.sv
// ----------------------------------------------------------------------------
// FAT16 cluster chain streamer address unit
// Shared sector-to-byte address unit: scales a sector number by the sector
// size and adds a byte offset, wrapping to the storage address width.
// ----------------------------------------------------------------------------
module fccs_addr_unit
  import fccs_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = SectorBytesDefault
) (
  input  logic [AddrW-1:0] sector_i,
  input  logic [AddrW-1:0] offset_i,
  output logic [AddrW-1:0] addr_o
);

  logic [AddrW-1:0] scaled;

  assign scaled = sector_i * AddrW'(SECTOR_BYTES);
  assign addr_o = scaled + offset_i;

endmodule
